### rtl/core/sapq_pkg.sv
// sapq_pkg: shared types and constants of the sorted array priority queue
// used by sorted_array_priority_queue_unit and sapq_checker; no dependencies

package sapq_pkg;

   localparam int DEPTH_DEFAULT       = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   localparam int FIELD_VALUE_WIDTH = 32;
   localparam int FIELD_COUNT_WIDTH = 5;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_DELETE = 1'b1;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_FULL  = 2'd1;
   localparam logic [1:0] ERR_EMPTY = 2'd2;

   typedef struct packed {
      logic                                mode;
      logic signed [FIELD_VALUE_WIDTH-1:0] insert_value;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_VALUE_WIDTH-1:0] head_value;
      logic [FIELD_COUNT_WIDTH-1:0]        entry_count;
      logic                                is_empty;
      logic                                is_full;
      logic [1:0]                          error_code;
   } rsp_type;

endpackage

### rtl/core/sorted_array_priority_queue_unit.sv
// sorted_array_priority_queue_unit: min priority queue held as a sorted row of cells
// depends on sapq_pkg for the item types, codes and parameter defaults
//
// usage
//   req channel: valid/ready, payload carries mode (insert or delete-min) and
//   insert_value. rsp channel: valid/ready, one item per request with the new
//   head, entry count, empty/full flags and an error code.
//   every stored entry compares against the new value in parallel and shifts by
//   one place, so each operation is a single pass through the cell row.
//   a request taken is held in the input register, and its rsp item is written
//   to the rsp register together with the cell row update when it advances.
//   throughput: one item per cycle while rsp is not stalled, as the cell row
//   and count register are updated as each item advances.
//   insert on a full queue is dropped with error 1; delete on an empty queue
//   leaves the state alone with error 2.
//   reset clears the count and both valid flags; entry storage is not cleared.
//   a stalled rsp holds its item; the input register still takes one more
//   item, then req_ready drops until rsp is taken.

module sorted_array_priority_queue_unit #(
   parameter int DEPTH       = sapq_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = sapq_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sapq_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sapq_pkg::rsp_type rsp_payload
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int FVW = sapq_pkg::FIELD_VALUE_WIDTH;
   localparam int FCW = sapq_pkg::FIELD_COUNT_WIDTH;

   logic              s1_valid_ff, s1_valid_in;
   sapq_pkg::req_type s1_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   sapq_pkg::rsp_type rsp_ff, rsp_in;
   logic [CW-1:0]     count_ff, count_in;

   logic signed [VALUE_WIDTH-1:0] entry_ff [DEPTH];
   logic signed [VALUE_WIDTH-1:0] entry_in [DEPTH];

   logic [DEPTH-1:0]              at_or_after;
   logic signed [VALUE_WIDTH-1:0] ins_value;
   logic [VALUE_WIDTH+FVW-1:0]    ins_ext;
   logic [VALUE_WIDTH+FVW-1:0]    head_ext;
   logic [CW+FCW-1:0]             count_ext;
   logic                          advance;
   logic                          full_now, empty_now;
   logic                          do_insert, do_delete;
   logic [1:0]                    err;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   // input value sign-extended or truncated to the storage width
   assign ins_ext   = {{VALUE_WIDTH{s1_ff.insert_value[FVW-1]}}, s1_ff.insert_value};
   assign ins_value = ins_ext[VALUE_WIDTH-1:0];

   assign full_now  = (count_ff == CW'(DEPTH));
   assign empty_now = (count_ff == '0);
   assign do_insert = advance && (s1_ff.mode == sapq_pkg::MODE_INSERT) && !full_now;
   assign do_delete = advance && (s1_ff.mode == sapq_pkg::MODE_DELETE) && !empty_now;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      // cell lies at or past the insertion point
      assign at_or_after[i] = (CW'(i) >= count_ff) || (entry_ff[i] > ins_value);

      if (i == 0) begin : g_first
         always_comb begin
            if (do_delete) begin
               entry_in[i] = entry_ff[i+1];
            end else if (do_insert) begin
               entry_in[i] = at_or_after[i] ? ins_value : entry_ff[i];
            end else begin
               entry_in[i] = entry_ff[i];
            end
         end
      end else if (i == DEPTH - 1) begin : g_last
         always_comb begin
            if (do_delete) begin
               entry_in[i] = entry_ff[i];
            end else if (do_insert && at_or_after[i]) begin
               entry_in[i] = at_or_after[i-1] ? entry_ff[i-1] : ins_value;
            end else begin
               entry_in[i] = entry_ff[i];
            end
         end
      end else begin : g_mid
         always_comb begin
            if (do_delete) begin
               entry_in[i] = entry_ff[i+1];
            end else if (do_insert && at_or_after[i]) begin
               entry_in[i] = at_or_after[i-1] ? entry_ff[i-1] : ins_value;
            end else begin
               entry_in[i] = entry_ff[i];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      err      = sapq_pkg::ERR_NONE;
      if (advance) begin
         case (s1_ff.mode)
            sapq_pkg::MODE_INSERT: begin
               if (full_now) begin
                  err = sapq_pkg::ERR_FULL;
               end else begin
                  count_in = count_ff + CW'(1);
               end
            end
            sapq_pkg::MODE_DELETE: begin
               if (empty_now) begin
                  err = sapq_pkg::ERR_EMPTY;
               end else begin
                  count_in = count_ff - CW'(1);
               end
            end
            default: begin
               err = sapq_pkg::ERR_NONE;
            end
         endcase
      end
   end

   assign head_ext  = {{FVW{entry_in[0][VALUE_WIDTH-1]}}, entry_in[0]};
   assign count_ext = {{FCW{1'b0}}, count_in};

   always_comb begin
      rsp_in.head_value  = (count_in == '0) ? '0 : head_ext[FVW-1:0];
      rsp_in.entry_count = count_ext[FCW-1:0];
      rsp_in.is_empty    = (count_in == '0);
      rsp_in.is_full     = (count_in == CW'(DEPTH));
      rsp_in.error_code  = err;
   end

   assign s1_valid_in  = req_ready ? req_valid : s1_valid_ff;
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         s1_ff <= req_payload;
      end
      if (advance) begin
         rsp_ff   <= rsp_in;
         entry_ff <= entry_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

### rtl/core/sapq_checker.sv
// sapq_checker: port-level checks on the rsp channel of the priority queue
// depends on sapq_pkg; bound to sorted_array_priority_queue_unit below

module sapq_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input sapq_pkg::rsp_type rsp_payload
);

   // stalled item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp item changed while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.is_empty == (rsp_payload.entry_count == '0))
      else $error("empty flag disagrees with count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.is_empty |-> rsp_payload.head_value == '0)
      else $error("head not zero on empty queue");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.error_code == sapq_pkg::ERR_FULL |-> rsp_payload.is_full)
      else $error("full error without full flag");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.error_code == sapq_pkg::ERR_EMPTY |-> rsp_payload.is_empty)
      else $error("empty error without empty flag");

endmodule

bind sorted_array_priority_queue_unit sapq_checker u_sapq_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

### tb/tb.sv
// tb: self-checking testbench for sorted_array_priority_queue_unit, the min priority queue
// keeps a shadow sorted queue to predict each result, drives random idling and back-pressure
// depends on sapq_pkg and sorted_array_priority_queue_unit

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH = sapq_pkg::DEPTH_DEFAULT;
   localparam int VALUE_BITS = sapq_pkg::FIELD_VALUE_WIDTH;
   localparam int COUNT_BITS = sapq_pkg::FIELD_COUNT_WIDTH;
   localparam int CYCLE_LIMIT = 60000;
   localparam int REPORT_LIMIT = 10;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   sapq_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   sapq_pkg::rsp_type rsp_payload;

   logic signed [VALUE_BITS-1:0] shadow_entries [QUEUE_DEPTH];
   int shadow_count = 0;
   sapq_pkg::rsp_type expected_status [$];

   bit idle_on = 1'b0;
   int hold_request = 0;
   int cycle_count = 0;
   int error_count = 0;
   int items_sent = 0;
   int results_checked = 0;
   int insert_count = 0;
   int delete_count = 0;
   int full_drops = 0;
   int empty_deletes = 0;
   int peak_count = 0;

   sorted_array_priority_queue_unit #(
      .DEPTH       (QUEUE_DEPTH),
      .VALUE_WIDTH (sapq_pkg::VALUE_WIDTH_DEFAULT)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic sapq_pkg::rsp_type apply_queue_op(sapq_pkg::req_type item);
      sapq_pkg::rsp_type result;
      logic signed [VALUE_BITS-1:0] value;
      int slot;
      result = '0;
      result.error_code = sapq_pkg::ERR_NONE;
      value = $signed(item.insert_value);
      if (item.mode == sapq_pkg::MODE_INSERT) begin
         insert_count++;
         if (shadow_count >= QUEUE_DEPTH) begin
            result.error_code = sapq_pkg::ERR_FULL;
            full_drops++;
         end else begin
            slot = shadow_count;
            for (int i = 0; i < shadow_count; i++) begin
               if (slot == shadow_count && shadow_entries[i] > value) slot = i;
            end
            for (int i = shadow_count; i > slot; i--) shadow_entries[i] = shadow_entries[i-1];
            shadow_entries[slot] = value;
            shadow_count++;
            if (shadow_count > peak_count) peak_count = shadow_count;
         end
      end else begin
         delete_count++;
         if (shadow_count == 0) begin
            result.error_code = sapq_pkg::ERR_EMPTY;
            empty_deletes++;
         end else begin
            for (int i = 1; i < shadow_count; i++) shadow_entries[i-1] = shadow_entries[i];
            shadow_count--;
         end
      end
      result.head_value  = (shadow_count != 0) ? shadow_entries[0] : '0;
      result.entry_count = COUNT_BITS'(shadow_count);
      result.is_empty    = (shadow_count == 0);
      result.is_full     = (shadow_count == QUEUE_DEPTH);
      return result;
   endfunction

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         expected_status = {expected_status, apply_queue_op(req_payload)};
      end
   end

   task automatic note_failure(input string text);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("%0d: %s", cycle_count, text);
   endtask

   always @(posedge clock) begin : check_results
      sapq_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (expected_status.size() == 0) begin
            note_failure($sformatf("unexpected result: head %0d count %0d err %0d",
               $signed(rsp_payload.head_value), rsp_payload.entry_count,
               rsp_payload.error_code));
         end else begin
            want = expected_status.pop_front();
            if (want.head_value !== rsp_payload.head_value
                  || want.entry_count !== rsp_payload.entry_count
                  || want.is_empty !== rsp_payload.is_empty
                  || want.is_full !== rsp_payload.is_full
                  || want.error_code !== rsp_payload.error_code) begin
               note_failure({
                  $sformatf("mismatch: expected head %0d count %0d empty %0b full %0b err %0d",
                     $signed(want.head_value), want.entry_count, want.is_empty,
                     want.is_full, want.error_code),
                  $sformatf(", got head %0d count %0d empty %0b full %0b err %0d",
                     $signed(rsp_payload.head_value), rsp_payload.entry_count,
                     rsp_payload.is_empty, rsp_payload.is_full, rsp_payload.error_code)});
            end
         end
      end
   end

   // receiver: long hold when asked, random stall bursts while idling is on
   initial begin : drive_rsp_ready
      int burst;
      @(posedge clock);
      forever begin
         if (hold_request > 0) begin
            burst = hold_request;
            hold_request = 0;
            rsp_ready <= 1'b0;
            repeat (burst) @(posedge clock);
         end else if (idle_on && $urandom_range(0, 4) == 0) begin
            burst = $urandom_range(1, 5);
            rsp_ready <= 1'b0;
            repeat (burst) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   function automatic logic signed [VALUE_BITS-1:0] pick_value();
      case ($urandom_range(0, 7))
         0, 1: return $urandom;
         2: return 32'h8000_0000 + $urandom_range(0, 3);
         3: return 32'h7fff_ffff - $urandom_range(0, 3);
         4, 5: return $urandom_range(0, 8) - 4;
         default: return $urandom_range(0, 2000) - 1000;
      endcase
   endfunction

   function automatic sapq_pkg::req_type make_item(logic mode,
         logic signed [VALUE_BITS-1:0] value);
      sapq_pkg::req_type item;
      item.mode = mode;
      item.insert_value = value;
      return item;
   endfunction

   function automatic sapq_pkg::req_type random_item(int insert_pct);
      return make_item(($urandom_range(0, 99) < insert_pct) ? sapq_pkg::MODE_INSERT
         : sapq_pkg::MODE_DELETE, pick_value());
   endfunction

   task automatic send_item(input sapq_pkg::req_type item);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 5);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic test_directed_edges();
      idle_on = 1'b1;
      send_item(make_item(sapq_pkg::MODE_DELETE, 32'h7fff_ffff));
      send_item(make_item(sapq_pkg::MODE_INSERT, 32'h7fff_ffff));
      send_item(make_item(sapq_pkg::MODE_INSERT, 32'h8000_0000));
      send_item(make_item(sapq_pkg::MODE_INSERT, '0));
      send_item(make_item(sapq_pkg::MODE_INSERT, -1));
      send_item(make_item(sapq_pkg::MODE_INSERT, '0));
      send_item(make_item(sapq_pkg::MODE_INSERT, 32'h8000_0000));
      repeat (QUEUE_DEPTH - 6) send_item(make_item(sapq_pkg::MODE_INSERT, pick_value()));
      send_item(make_item(sapq_pkg::MODE_INSERT, 32'h8000_0000));
      send_item(make_item(sapq_pkg::MODE_DELETE, '1));
      send_item(make_item(sapq_pkg::MODE_INSERT, 32'h7fff_ffff));
      send_item(make_item(sapq_pkg::MODE_INSERT, 32'h7fff_ffff));
      repeat (3) send_item(make_item(sapq_pkg::MODE_DELETE, '0));
   endtask

   task automatic test_random_mix();
      int remaining;
      int run_len;
      int insert_pct;
      remaining = 300;
      while (remaining > 0) begin
         run_len = $urandom_range(8, 40);
         if (run_len > remaining) run_len = remaining;
         case ($urandom_range(0, 2))
            0: insert_pct = 85;
            1: insert_pct = 15;
            default: insert_pct = 50;
         endcase
         idle_on = ($urandom_range(0, 3) != 0);
         repeat (run_len) send_item(random_item(insert_pct));
         remaining -= run_len;
      end
   endtask

   task automatic test_backpressure();
      idle_on = 1'b1;
      repeat (2) begin
         hold_request = 60;
         repeat (12) send_item(random_item(60));
      end
   endtask

   task automatic test_back_to_back();
      idle_on = 1'b0;
      repeat (QUEUE_DEPTH + 4) send_item(make_item(sapq_pkg::MODE_INSERT, pick_value()));
      repeat (QUEUE_DEPTH + 4) send_item(make_item(sapq_pkg::MODE_DELETE, pick_value()));
      repeat (60) send_item(random_item(50));
   endtask

   initial begin : run_tests
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_random_mix();
      test_backpressure();
      test_back_to_back();
      req_valid <= 1'b0;
      while (results_checked < items_sent || expected_status.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      $display("covered %0d items: %0d inserts, %0d delete-min, %0d full drops, %0d on empty",
         items_sent, insert_count, delete_count, full_drops, empty_deletes);
      $display("peak depth %0d of %0d, %0d results checked, %0d failures",
         peak_count, QUEUE_DEPTH, results_checked, error_count);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
